[design/segl1_pkg.sv]
package segl1_pkg;

  localparam int unsigned MAX_ROWS_DEF    = 1024;
  localparam int unsigned MAX_COLUMNS_DEF = 4;

  localparam int unsigned SEG_W    = 11;
  localparam int unsigned ROW_W    = 10;
  localparam int unsigned COLI_W   = 2;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COST_W   = 44;
  localparam int unsigned RCNT_W   = 11;
  localparam int unsigned CCNT_W   = 3;
  localparam int unsigned BIT_W    = 5;

  localparam logic [SAMPLE_W-1:0] SIGN_BIAS = 32'h8000_0000;

  localparam logic [0:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [0:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              status;
  } result_t;

endpackage

[design/segl1_store.sv]
module segl1_store #(
  parameter int unsigned DEPTH  = segl1_pkg::MAX_ROWS_DEF * segl1_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [ADDR_W-1:0]                 waddr,
  input  logic [segl1_pkg::SAMPLE_W-1:0]    wdata,
  input  logic                              re,
  input  logic [ADDR_W-1:0]                 raddr,
  output logic [segl1_pkg::SAMPLE_W-1:0]    rdata
);

  logic [segl1_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/segl1_engine.sv]
module segl1_engine #(
  parameter int unsigned MAX_ROWS    = segl1_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = segl1_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned ADDR_W      = $clog2(MAX_ROWS * MAX_COLUMNS),
  parameter int unsigned COL_CW      = $clog2(MAX_COLUMNS + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [segl1_pkg::SEG_W-1:0]      seg_start,
  input  logic [segl1_pkg::SEG_W-1:0]      seg_end,
  input  logic [segl1_pkg::RCNT_W-1:0]     row_count,
  input  logic [segl1_pkg::CCNT_W-1:0]     column_count,
  output logic                             idle,
  output logic                             rd_en,
  output logic [ADDR_W-1:0]                rd_addr,
  input  logic [segl1_pkg::SAMPLE_W-1:0]   rd_data,
  output logic                             res_valid,
  output segl1_pkg::result_t               res,
  input  logic                             res_ack
);

  localparam int unsigned SW    = segl1_pkg::SEG_W;
  localparam int unsigned DW    = segl1_pkg::SAMPLE_W;
  localparam int unsigned ACC_W = DW + SW + COL_CW + 1;
  localparam logic [ACC_W-1:0] COST_MAX = ACC_W'({segl1_pkg::COST_W{1'b1}});

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [SW-1:0]            start_r, start_nxt, end_r, end_nxt, row_r, row_nxt;
  logic [SW-1:0]            k_r, k_nxt, k0_r, k0_nxt, cnt_r, cnt_nxt;
  logic [COL_CW-1:0]        cols_r, cols_nxt, col_r, col_nxt;
  logic [segl1_pkg::BIT_W-1:0] bit_r, bit_nxt;
  logic [DW-1:0]            prefix_r, prefix_nxt;
  logic                     issue_done_r, issue_done_nxt, pend_r, pend_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  segl1_pkg::result_t       res_r, res_nxt;

  logic [DW-1:0]  biased, hi_mask, diff;
  logic [DW:0]    mask_wide;
  logic           match, pass_end, too_far, short_seg;
  logic [SW-1:0]  len;
  logic [COL_CW-1:0] cols_sat;
  logic [31:0]    addr_full;

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  assign rd_en     = ((state_r == ST_SCAN) || (state_r == ST_SUM)) && !issue_done_r;
  assign addr_full = 32'(row_r) * MAX_COLUMNS + 32'(col_r);
  assign rd_addr   = addr_full[ADDR_W-1:0];

  assign biased    = rd_data ^ segl1_pkg::SIGN_BIAS;
  assign mask_wide = {(DW+1){1'b1}} << (6'(bit_r) + 6'd1);
  assign hi_mask   = mask_wide[DW-1:0];
  assign match     = (((biased ^ prefix_r) & hi_mask) == '0) && !biased[bit_r];
  assign diff      = (biased > prefix_r) ? (biased - prefix_r) : (prefix_r - biased);
  assign pass_end  = issue_done_r && !pend_r;

  assign too_far   = (32'(seg_end) > 32'(row_count)) || (32'(seg_end) > MAX_ROWS);
  assign short_seg = (seg_start >= seg_end) || ((seg_end - seg_start) <= SW'(1));
  assign len       = seg_end - seg_start;
  assign cols_sat  = (32'(column_count) > MAX_COLUMNS) ? COL_CW'(MAX_COLUMNS)
                                                      : COL_CW'(column_count);

  always_comb begin
    state_nxt      = state_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    row_nxt        = row_r;
    k_nxt          = k_r;
    k0_nxt         = k0_r;
    cnt_nxt        = cnt_r;
    cols_nxt       = cols_r;
    col_nxt        = col_r;
    bit_nxt        = bit_r;
    prefix_nxt     = prefix_r;
    issue_done_nxt = issue_done_r;
    pend_nxt       = rd_en;
    acc_nxt        = acc_r;
    res_nxt        = res_r;

    if (rd_en) begin
      row_nxt = row_r + SW'(1);
      if (row_r + SW'(1) == end_r) begin
        issue_done_nxt = 1'b1;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          start_nxt      = seg_start;
          end_nxt        = seg_end;
          row_nxt        = seg_start;
          cols_nxt       = cols_sat;
          col_nxt        = '0;
          bit_nxt        = segl1_pkg::BIT_W'(DW - 1);
          prefix_nxt     = '0;
          cnt_nxt        = '0;
          k_nxt          = (len + SW'(1)) >> 1;
          k0_nxt         = (len + SW'(1)) >> 1;
          acc_nxt        = '0;
          issue_done_nxt = 1'b0;
          res_nxt.cost   = '0;
          res_nxt.status = too_far;
          if (too_far || short_seg || (cols_sat == '0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (pend_r && match) begin
          cnt_nxt = cnt_r + SW'(1);
        end
        if (pass_end) begin
          cnt_nxt        = '0;
          row_nxt        = start_r;
          issue_done_nxt = 1'b0;
          if (k_r > cnt_r) begin
            prefix_nxt = prefix_r | (DW'(1) << bit_r);
            k_nxt      = k_r - cnt_r;
          end
          if (bit_r == '0) begin
            state_nxt = ST_SUM;
          end else begin
            bit_nxt = bit_r - segl1_pkg::BIT_W'(1);
          end
        end
      end
      ST_SUM: begin
        if (pend_r) begin
          acc_nxt = acc_r + ACC_W'(diff);
        end
        if (pass_end) begin
          row_nxt        = start_r;
          issue_done_nxt = 1'b0;
          if (col_r + COL_CW'(1) == cols_r) begin
            res_nxt.cost = (acc_r > COST_MAX) ? segl1_pkg::COST_W'(COST_MAX)
                                              : acc_r[segl1_pkg::COST_W-1:0];
            state_nxt    = ST_DONE;
          end else begin
            col_nxt    = col_r + COL_CW'(1);
            bit_nxt    = segl1_pkg::BIT_W'(DW - 1);
            prefix_nxt = '0;
            k_nxt      = k0_r;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_DONE: begin
        if (res_ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_done_r <= 1'b1;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    end_r    <= end_nxt;
    row_r    <= row_nxt;
    k_r      <= k_nxt;
    k0_r     <= k0_nxt;
    cnt_r    <= cnt_nxt;
    cols_r   <= cols_nxt;
    col_r    <= col_nxt;
    bit_r    <= bit_nxt;
    prefix_r <= prefix_nxt;
    acc_r    <= acc_nxt;
    res_r    <= res_nxt;
  end

endmodule

[design/segment_l1_median_cost_core.sv]
// Segment L1 median cost core. Samples (signed Q16.16) are loaded one request
// at a time into a single-port-write / single-port-read sample memory of
// MAX_ROWS x MAX_COLUMNS words; a load returns nothing.
// A query request over rows [seg_start, seg_end) returns one result: for each
// active column the lower median is found by a bitwise radix search (32
// passes over the segment, one memory read per row per pass), then one more
// pass sums the absolute deviations. The engine issues one sample memory read
// per cycle while it passes over the segment; errored or short segments skip
// the passes. New requests are taken only while the engine is idle; a
// finished result waits in the output register without blocking loads.
// Reading a store entry that was never loaded gives an undefined cost.
module segment_l1_median_cost_core #(
  parameter int unsigned MAX_ROWS    = segl1_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = segl1_pkg::MAX_COLUMNS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [segl1_pkg::ROW_W-1:0]         in_row_index,
  input  logic [segl1_pkg::COLI_W-1:0]        in_column_index,
  input  logic signed [segl1_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [segl1_pkg::SEG_W-1:0]         in_seg_start,
  input  logic [segl1_pkg::SEG_W-1:0]         in_seg_end,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [segl1_pkg::COST_W-1:0]        out_cost,
  output logic                                out_status,
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [2:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned COL_CW = $clog2(MAX_COLUMNS + 1);

  logic [segl1_pkg::RCNT_W-1:0] row_count_r;
  logic [segl1_pkg::CCNT_W-1:0] column_count_r;
  logic                         out_valid_r, out_valid_nxt;
  segl1_pkg::result_t           out_r;

  logic                           eng_idle, eng_res_valid, res_ack;
  logic                           rd_en;
  logic [ADDR_W-1:0]              rd_addr;
  logic [segl1_pkg::SAMPLE_W-1:0] rd_data;
  segl1_pkg::result_t             eng_res;

  logic           accept, load_we, cfg_we;
  logic [31:0]    waddr_full;

  // APB: zero wait state, write lands on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= '0;
      column_count_r <= segl1_pkg::CCNT_W'(1);
    end else if (cfg_we) begin
      if (cfg_paddr[2] == segl1_pkg::REG_ROW_COUNT) begin
        row_count_r <= cfg_pwdata[segl1_pkg::RCNT_W-1:0];
      end else begin
        column_count_r <= cfg_pwdata[segl1_pkg::CCNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == segl1_pkg::REG_ROW_COUNT) begin
      cfg_prdata = 32'(row_count_r);
    end else begin
      cfg_prdata = 32'(column_count_r);
    end
  end

  // one request at a time through the engine
  assign in_ready = eng_idle;
  assign accept   = in_valid && in_ready;

  // loads outside the store are dropped
  assign load_we = accept && (in_command == segl1_pkg::CMD_LOAD)
                   && (32'(in_row_index) < MAX_ROWS)
                   && (32'(in_column_index) < MAX_COLUMNS);
  assign waddr_full = 32'(in_row_index) * MAX_COLUMNS + 32'(in_column_index);

  segl1_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr_full[ADDR_W-1:0]),
    .wdata (in_sample_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  segl1_engine #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .ADDR_W      (ADDR_W),
    .COL_CW      (COL_CW)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (accept && (in_command == segl1_pkg::CMD_QUERY)),
    .seg_start    (in_seg_start),
    .seg_end      (in_seg_end),
    .row_count    (row_count_r),
    .column_count (column_count_r),
    .idle         (eng_idle),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .res_valid    (eng_res_valid),
    .res          (eng_res),
    .res_ack      (res_ack)
  );

  // output register: engine hands over when the slot is free or draining
  assign res_ack = eng_res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_ack) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_r <= eng_res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_cost   = out_r.cost;
  assign out_status = out_r.status;

endmodule

[design/segl1_checker.sv]
module segl1_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [43:0] out_cost,
  input logic        out_status
);

  // a result that waits keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cost) && $stable(out_status))
    else $error("result changed while stalled");

  // error status always carries zero cost
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_cost == 44'd0)
    else $error("error result with nonzero cost");

  // a query holds off the next request
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command |=> !in_ready)
    else $error("request taken during query");

  // a load makes no result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_command && !out_valid |=> !out_valid)
    else $error("result appeared after load");

endmodule

bind segment_l1_median_cost_core segl1_checker u_segl1_checker (.*);

[tb/sv/segl1_cost_book.sv]
// Expected-result store and cost predictor for the segment L1 median core.
class segl1_cost_book;

  localparam longint unsigned COST_SAT = (64'd1 << segl1_pkg::COST_W) - 1;
  localparam int unsigned     NROW     = segl1_pkg::MAX_ROWS_DEF;
  localparam int unsigned     NCOL     = segl1_pkg::MAX_COLUMNS_DEF;

  logic [segl1_pkg::SAMPLE_W-1:0] samples [0:NROW*NCOL-1];
  bit                             loaded  [0:NROW*NCOL-1];
  int unsigned                    row_count;
  int unsigned                    column_count;
  segl1_pkg::result_t             pending_costs[$];
  int                             errors;

  function new();
    foreach (loaded[i]) loaded[i] = 1'b0;
    row_count    = 0;
    column_count = 1;
    errors       = 0;
  endfunction

  function void set_register(logic [0:0] idx, logic [31:0] value);
    if (idx == segl1_pkg::REG_ROW_COUNT) row_count = 32'(value[segl1_pkg::RCNT_W-1:0]);
    else column_count = 32'(value[segl1_pkg::CCNT_W-1:0]);
  endfunction

  function bit is_loaded(int unsigned row, int unsigned col);
    return loaded[row*NCOL + col];
  endfunction

  function int unsigned active_cols();
    return (column_count > NCOL) ? NCOL : column_count;
  endfunction

  // True when a query over [s, e) would read only loaded samples
  function bit query_safe(int unsigned s, int unsigned e);
    if (e > row_count || e > NROW) return 1'b1;
    if (s >= e || e - s <= 1) return 1'b1;
    for (int unsigned r = s; r < e; r++)
      for (int unsigned c = 0; c < active_cols(); c++)
        if (!loaded[r*NCOL + c]) return 1'b0;
    return 1'b1;
  endfunction

  function segl1_pkg::result_t segment_cost(int unsigned s, int unsigned e);
    segl1_pkg::result_t res;
    bit [31:0]          vals[$];
    bit [31:0]          med;
    longint unsigned    total;
    int unsigned        len;
    res.cost   = '0;
    res.status = 1'b0;
    total      = 0;
    if (e > row_count || e > NROW) begin
      res.status = 1'b1;
      return res;
    end
    if (s >= e || e - s <= 1) return res;
    len = e - s;
    for (int unsigned c = 0; c < active_cols(); c++) begin
      vals.delete();
      for (int unsigned r = s; r < e; r++)
        vals.push_back(samples[r*NCOL + c] ^ segl1_pkg::SIGN_BIAS);
      vals.sort();
      med = vals[(len + 1) / 2 - 1];
      foreach (vals[i])
        total += (vals[i] > med) ? longint'(vals[i] - med) : longint'(med - vals[i]);
      if (total > COST_SAT) total = COST_SAT;
    end
    res.cost = total[segl1_pkg::COST_W-1:0];
    return res;
  endfunction

  function void note_request(logic cmd, logic [segl1_pkg::ROW_W-1:0] row,
                             logic [segl1_pkg::COLI_W-1:0] col,
                             logic [segl1_pkg::SAMPLE_W-1:0] value,
                             logic [segl1_pkg::SEG_W-1:0] s,
                             logic [segl1_pkg::SEG_W-1:0] e);
    if (cmd == segl1_pkg::CMD_LOAD) begin
      samples[row*NCOL + col] = value;
      loaded[row*NCOL + col]  = 1'b1;
    end else begin
      pending_costs.push_back(segment_cost(s, e));
    end
  endfunction

  function void check_result(logic [segl1_pkg::COST_W-1:0] cost, logic status);
    segl1_pkg::result_t exp_r;
    if (pending_costs.size() == 0) begin
      $display("%0t: unexpected result cost=%0d status=%0d", $time, cost, status);
      errors++;
      return;
    end
    exp_r = pending_costs.pop_front();
    if (cost !== exp_r.cost) begin
      $display("%0t: cost mismatch expected %0d actual %0d", $time, exp_r.cost, cost);
      errors++;
    end
    if (status !== exp_r.status) begin
      $display("%0t: status mismatch expected %0d actual %0d", $time, exp_r.status, status);
      errors++;
    end
  endfunction

  function int pending();
    return pending_costs.size();
  endfunction
endclass

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // generous: slowest run is well under half of this
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 22;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic                                in_command;
  logic [segl1_pkg::ROW_W-1:0]         in_row_index;
  logic [segl1_pkg::COLI_W-1:0]        in_column_index;
  logic [segl1_pkg::SAMPLE_W-1:0]      in_sample_value;
  logic [segl1_pkg::SEG_W-1:0]         in_seg_start;
  logic [segl1_pkg::SEG_W-1:0]         in_seg_end;
  logic                                out_valid;
  logic                                out_ready;
  logic [segl1_pkg::COST_W-1:0]        out_cost;
  logic                                out_status;
  logic                                cfg_psel;
  logic                                cfg_penable;
  logic                                cfg_pwrite;
  logic [2:0]                          cfg_paddr;
  logic [31:0]                         cfg_pwdata;
  logic [31:0]                         cfg_prdata;
  logic                                cfg_pready;

  segl1_cost_book book = new();

  int unsigned cycles = 0;
  int unsigned sent   = 0;
  bit          hold_req = 1'b0;   // asks the result side for a long hold-off

  segment_l1_median_cost_core dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random ready pattern, plus one long hold-off on request.
  int unsigned run_left   = 0;
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) book.check_result(out_cost, out_status);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 2000;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            out_ready <= 1'b1;
            run_left = $urandom_range(0, 20);
          end
          5, 6, 7, 8: begin
            out_ready <= 1'b0;
            run_left = $urandom_range(0, 3);
          end
          default: begin
            out_ready <= 1'b0;
            run_left = $urandom_range(30, 100);
          end
        endcase
      end
    end
  end

  // Offer one request and wait for its acceptance. in_valid stays high on
  // return; the caller lowers it when a gap follows.
  task automatic send_req(logic cmd, logic [segl1_pkg::ROW_W-1:0] row,
                          logic [segl1_pkg::COLI_W-1:0] col,
                          logic [segl1_pkg::SAMPLE_W-1:0] value,
                          logic [segl1_pkg::SEG_W-1:0] s,
                          logic [segl1_pkg::SEG_W-1:0] e);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_row_index    <= row;
    in_column_index <= col;
    in_sample_value <= value;
    in_seg_start    <= s;
    in_seg_end      <= e;
    do @(posedge clk); while (!in_ready);
    book.note_request(cmd, row, col, value, s, e);
    sent++;
  endtask

  task automatic sender_gap();
    int unsigned n;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(20, 80);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic load(int unsigned row, int unsigned col, logic [31:0] value);
    send_req(segl1_pkg::CMD_LOAD, row[segl1_pkg::ROW_W-1:0], col[segl1_pkg::COLI_W-1:0],
             value, segl1_pkg::SEG_W'($urandom), segl1_pkg::SEG_W'($urandom));
    sender_gap();
  endtask

  task automatic query(int unsigned s, int unsigned e);
    send_req(segl1_pkg::CMD_QUERY, segl1_pkg::ROW_W'($urandom),
             segl1_pkg::COLI_W'($urandom), $urandom,
             s[segl1_pkg::SEG_W-1:0], e[segl1_pkg::SEG_W-1:0]);
    sender_gap();
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return $urandom_range(0, 8) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Loads every missing sample of [s, e) in the active columns
  task automatic fill_segment(int unsigned s, int unsigned e);
    for (int unsigned r = s; r < e; r++)
      for (int unsigned c = 0; c < book.active_cols(); c++)
        if (!book.is_loaded(r, c)) load(r, c, rand_sample());
  endtask

  // Idle point: sender stopped, all results in, trailing load retired.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [0:0] idx, int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    book.set_register(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned rows, int unsigned cols);
    drain();
    reg_write(segl1_pkg::REG_ROW_COUNT, rows);
    reg_write(segl1_pkg::REG_COLUMN_COUNT, cols);
  endtask

  // One random phase: well-formed queries over loaded rows, with
  // stray loads, error segments and raw noise mixed in.
  task automatic random_phase(bit with_hold);
    int unsigned start_cnt;
    int unsigned lim;
    int unsigned s;
    int unsigned e;
    int unsigned len;
    int unsigned r;
    bit          hold_done;
    bit          pause_done;
    start_cnt  = sent;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    lim = (book.row_count > segl1_pkg::MAX_ROWS_DEF) ? segl1_pkg::MAX_ROWS_DEF
                                                      : book.row_count;
    while (sent - start_cnt < ITEMS_PER_PHASE) begin
      if (with_hold && !hold_done && sent - start_cnt >= 10) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (with_hold && !pause_done && sent - start_cnt >= 18) begin
        // full stop until every result is back
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 40 && lim >= 2) begin
        len = $urandom_range(2, (lim < 10) ? lim : 10);
        s   = $urandom_range(0, ((lim < 64) ? lim : 64) - len);
        e   = s + len;
        fill_segment(s, e);
        query(s, e);
      end else if (r < 55) begin
        load($urandom_range(0, 1023), $urandom_range(0, 3), rand_sample());
      end else if (r < 65) begin
        load($urandom_range(0, 63), $urandom_range(0, 3), rand_sample());
      end else if (r < 80) begin
        e = $urandom_range(lim + 1, 2047);
        query($urandom_range(0, 2047), e);
      end else begin
        s = $urandom_range(0, 2047);
        e = $urandom_range(0, 2047);
        if (!book.query_safe(s, e)) s = e;
        query(s, e);
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = segl1_pkg::CMD_LOAD;
    in_row_index    = '0;
    in_column_index = '0;
    in_sample_value = '0;
    in_seg_start    = '0;
    in_seg_end      = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no rows valid, so any nonempty end is flagged.
    query(0, 1);
    query(0, 0);
    query(2047, 2047);
    load(1023, 3, 32'h7fff_ffff);
    load(0, 0, 32'h8000_0000);

    // Column 0 of the first 64 rows loaded back to back, then edge segments.
    configure(64, 1);
    for (int unsigned r = 0; r < 64; r++) begin
      send_req(segl1_pkg::CMD_LOAD, r[segl1_pkg::ROW_W-1:0], '0, rand_sample(), '0, '0);
    end
    query(0, 64);
    query(62, 64);
    query(0, 65);
    query(5, 3);
    query(7, 8);
    query(0, 2);
    query(64, 64);

    // No active columns: cost is zero whatever the segment.
    configure(1024, 0);
    query(0, 8);
    // Above the column limit: saturates to all four columns.
    configure(16, 7);
    fill_segment(0, 16);
    query(0, 16);
    query(3, 12);
    query(0, 17);

    configure(64, 4);
    random_phase(1'b1);
    configure(1024, 2);
    random_phase(1'b0);
    configure(2047, 3);
    random_phase(1'b0);
    configure(10, 1);
    random_phase(1'b0);
    configure(1024, 5);
    random_phase(1'b1);
    configure(1, 4);
    random_phase(1'b0);

    drain();
    repeat (50) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
